FILE: rtl/core/bavg_pkg.sv
package bavg_pkg;

    // Widths fixed by the register and result formats.
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH = 2'd1;

    localparam int DEF_MAX_SERIES_LENGTH = 1048576;
    localparam int DEF_SAMPLE_WIDTH      = 32;

    // Entries in the queue between the accumulator and the divider.
    localparam int QUEUE_DEPTH = 2;

    // Bits needed to hold a length up to and including the maximum.
    function automatic int len_width(input int max_len);
        return $clog2(max_len + 1);
    endfunction

    // The block sum needs sample width plus length width, and wraps at 64 bits.
    function automatic int sum_width(input int sample_w, input int len_w);
        return ((sample_w + len_w) > 64) ? 64 : (sample_w + len_w);
    endfunction

endpackage

FILE: rtl/core/bavg_sample_if.sv
interface bavg_sample_if #(
    parameter int SAMPLE_WIDTH = bavg_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/bavg_point_if.sv
interface bavg_point_if;
    logic                             valid;
    logic                             ready;
    logic signed [bavg_pkg::OUT_W-1:0] average;
    logic                             last_point;

    modport source (output valid, output average, output last_point, input ready);
    modport sink   (input valid, input average, input last_point, output ready);
endinterface

FILE: rtl/core/bavg_cfg_if.sv
interface bavg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bavg_pkg::CFG_IDX_W-1:0]    index;
    logic [bavg_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/block_average_decimator.sv
// Streams a series of in_length signed samples and emits out_length points, each the
// mean of one contiguous block, truncated toward zero; when in_length is at most
// out_length every sample is passed through unchanged. last_point marks the final
// point of a series, after which the next sample starts a new series; any write to
// register 0 (in_length) or 1 (out_length) also restarts the series and must be made
// while the block is idle. The front accumulates one sample per cycle, stalling only
// when a block closes and the queue is full, and feeds a two-entry queue; the back
// holds a radix-2 divider for blocks of two or more samples and takes no new block
// while it divides, while a block of one sample, including every pass-through
// sample, skips the divider. A point that needs no division passes from the queue
// entry through the back's hold state into the output register.
module block_average_decimator #(
    parameter int MAX_SERIES_LENGTH = bavg_pkg::DEF_MAX_SERIES_LENGTH,
    parameter int SAMPLE_WIDTH      = bavg_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    bavg_cfg_if.sink     cfg,
    bavg_sample_if.sink  samples,
    bavg_point_if.source points
);

    localparam int LEN_W = bavg_pkg::len_width(MAX_SERIES_LENGTH);
    localparam int SUM_W = bavg_pkg::sum_width(SAMPLE_WIDTH, LEN_W);
    localparam int JOB_W = 1 + LEN_W + SUM_W;

    logic             push_valid;
    logic             push_ready;
    logic [SUM_W-1:0] push_sum;
    logic [LEN_W-1:0] push_count;
    logic             push_last;
    logic             pop_valid;
    logic             pop_ready;
    logic [JOB_W-1:0] pop_data;

    bavg_front #(
        .MAX_SERIES_LENGTH (MAX_SERIES_LENGTH),
        .SAMPLE_WIDTH      (SAMPLE_WIDTH),
        .LEN_W             (LEN_W),
        .SUM_W             (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .samples   (samples),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_sum   (push_sum),
        .job_count (push_count),
        .job_last  (push_last)
    );

    bavg_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_last, push_count, push_sum}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bavg_back #(
        .MAX_SERIES_LENGTH (MAX_SERIES_LENGTH),
        .SAMPLE_WIDTH      (SAMPLE_WIDTH),
        .LEN_W             (LEN_W),
        .SUM_W             (SUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_sum   (pop_data[SUM_W-1:0]),
        .job_count (pop_data[SUM_W +: LEN_W]),
        .job_last  (pop_data[JOB_W-1]),
        .points    (points)
    );

endmodule

FILE: rtl/core/bavg_front.sv
module bavg_front #(
    parameter int MAX_SERIES_LENGTH = bavg_pkg::DEF_MAX_SERIES_LENGTH,
    parameter int SAMPLE_WIDTH      = bavg_pkg::DEF_SAMPLE_WIDTH,
    parameter int LEN_W             = bavg_pkg::len_width(MAX_SERIES_LENGTH),
    parameter int SUM_W             = bavg_pkg::sum_width(SAMPLE_WIDTH, LEN_W)
) (
    input  logic              clk,
    input  logic              rst_n,
    bavg_cfg_if.sink          cfg,
    bavg_sample_if.sink       samples,
    output logic              job_valid,
    input  logic              job_ready,
    output logic [SUM_W-1:0]  job_sum,
    output logic [LEN_W-1:0]  job_count,
    output logic              job_last
);

    localparam int CFG_W  = bavg_pkg::CFG_W;
    localparam int PROD_W = 2 * LEN_W + 1;
    localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SERIES_LENGTH);

    logic [CFG_W-1:0]  in_len_reg, in_len_next;
    logic [CFG_W-1:0]  out_len_reg, out_len_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              start_reg, start_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [PROD_W-1:0] b_reg, b_next;

    logic [CMP_W-1:0]  in_ext, out_ext, n_c, t_c;
    logic [LEN_W-1:0]  n, t;
    logic              pass_mode;
    logic              series_end;
    logic              close_block;
    logic [PROD_W-1:0] a_eff, b_eff;
    logic [SUM_W-1:0]  sum_add;
    logic [LEN_W-1:0]  count_add;
    logic              accept;
    logic              cfg_write;
    logic              cfg_hit;

    // A length of zero counts as one, and a length above the maximum as the maximum.
    always_comb
    begin
        in_ext  = CMP_W'(in_len_reg);
        out_ext = CMP_W'(out_len_reg);
        n_c = (in_ext == '0) ? CMP_W'(1) : ((in_ext > MAX_C) ? MAX_C : in_ext);
        t_c = (out_ext == '0) ? CMP_W'(1) : ((out_ext > MAX_C) ? MAX_C : out_ext);
        n = n_c[LEN_W-1:0];
        t = t_c[LEN_W-1:0];
    end

    // Block b closes at sample s when (b+1)*N < (s+2)*T. Both sides advance by
    // adding N per closed block and T per sample, so no division is needed.
    always_comb
    begin
        pass_mode   = (n <= t);
        series_end  = (({1'b0, idx_reg} + (LEN_W + 1)'(1)) >= {1'b0, n});
        a_eff       = start_reg ? PROD_W'(n) : a_reg;
        b_eff       = start_reg ? (PROD_W'(t) << 1) : b_reg;
        close_block = pass_mode || series_end || (a_eff < b_eff);
        sum_add     = sum_reg + SUM_W'(samples.sample);
        count_add   = count_reg + LEN_W'(1);
    end

    assign samples.ready = !close_block || job_ready;
    assign accept        = samples.valid && samples.ready;

    assign job_valid = samples.valid && close_block;
    assign job_sum   = sum_add;
    assign job_count = count_add;
    assign job_last  = series_end;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        in_len_next  = in_len_reg;
        out_len_next = out_len_reg;
        cfg_hit      = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg.index)
                bavg_pkg::REG_IN_LENGTH:
                begin
                    in_len_next = cfg.data;
                    cfg_hit     = 1'b1;
                end
                bavg_pkg::REG_OUT_LENGTH:
                begin
                    out_len_next = cfg.data;
                    cfg_hit      = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        if (cfg_hit || (accept && series_end))
        begin
            sum_next   = '0;
            count_next = '0;
            idx_next   = '0;
            start_next = 1'b1;
        end
        else if (accept)
        begin
            idx_next   = idx_reg + LEN_W'(1);
            start_next = 1'b0;
            b_next     = b_eff + PROD_W'(t);
            if (close_block)
            begin
                a_next     = a_eff + PROD_W'(n);
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                a_next     = a_eff;
                sum_next   = sum_add;
                count_next = count_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg  <= CFG_W'(1);
            out_len_reg <= CFG_W'(1);
            sum_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            start_reg   <= 1'b1;
        end
        else
        begin
            in_len_reg  <= in_len_next;
            out_len_reg <= out_len_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            start_reg   <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

`ifndef ASSERT_OFF
    a_series_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && series_end) |=> (idx_reg == '0) && start_reg && (count_reg == '0))
        else $error("series did not restart after its final sample");
`endif

endmodule

FILE: rtl/core/bavg_queue.sv
module bavg_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = bavg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + PTR_W'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + PTR_W'(1));
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/bavg_back.sv
module bavg_back #(
    parameter int MAX_SERIES_LENGTH = bavg_pkg::DEF_MAX_SERIES_LENGTH,
    parameter int SAMPLE_WIDTH      = bavg_pkg::DEF_SAMPLE_WIDTH,
    parameter int LEN_W             = bavg_pkg::len_width(MAX_SERIES_LENGTH),
    parameter int SUM_W             = bavg_pkg::sum_width(SAMPLE_WIDTH, LEN_W)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [SUM_W-1:0]  job_sum,
    input  logic [LEN_W-1:0]  job_count,
    input  logic              job_last,
    bavg_point_if.source      points
);

    localparam int OUT_W  = bavg_pkg::OUT_W;
    localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SUM_W-1:0]  dq_reg, dq_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  average_reg, average_next;
    logic              out_last_reg, out_last_next;

    logic              slot_free;
    logic              pop;
    logic [SUM_W-1:0]  mag;
    logic [LEN_W:0]    shifted;
    logic              fits;
    logic [LEN_W:0]    diff;
    logic [EXT_W-1:0]  q_ext;
    logic [EXT_W-1:0]  signed_q;

    assign slot_free = !out_valid_reg || points.ready;
    assign job_ready = (state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && slot_free);
    assign pop       = job_valid && job_ready;

    // Divide the magnitude and put the sign back afterwards, as truncation toward zero needs.
    assign mag = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;

    // One quotient bit per cycle: shift the next dividend bit into the remainder.
    always_comb
    begin
        shifted = {rem_reg, dq_reg[SUM_W-1]};
        fits    = (shifted >= {1'b0, div_reg});
        diff    = shifted - {1'b0, div_reg};
    end

    always_comb
    begin
        q_ext    = EXT_W'(dq_reg);
        signed_q = neg_reg ? (~q_ext + EXT_W'(1)) : q_ext;
    end

    always_comb
    begin
        state_next     = state_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !points.ready;
        average_next   = average_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                rem_next  = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
                dq_next   = {dq_reg[SUM_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    average_next   = signed_q[OUT_W-1:0];
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A block of one sample needs no division and goes straight to the result.
        if (pop)
        begin
            neg_next   = job_sum[SUM_W-1];
            dq_next    = mag;
            rem_next   = '0;
            div_next   = job_count;
            step_next  = '0;
            last_next  = job_last;
            state_next = (job_count == LEN_W'(1)) ? ST_HOLD : ST_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        step_reg     <= step_next;
        neg_reg      <= neg_next;
        last_reg     <= last_next;
        average_reg  <= average_next;
        out_last_reg <= out_last_next;
    end

    assign points.valid      = out_valid_reg;
    assign points.average    = average_reg;
    assign points.last_point = out_last_reg;

`ifndef ASSERT_OFF
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("division remainder reached the divisor");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (div_reg != '0))
        else $error("divider holds a zero count");

    a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && slot_free) |=> points.valid)
        else $error("finished quotient was not placed in the output register");
`endif

endmodule
